// ----- hdl/fbm_pkg.sv -----
// Shared types and constants for the fractal value-noise height pipeline.
// No dependencies; used by fbm_octave, fbm_norm and fbm_value_noise_height.
package fbm_pkg;

    // Default sizing of the pipeline
    localparam int DEF_MAX_OCTAVES       = 8;
    localparam int DEF_MAX_COLUMN_HEIGHT = 1024;

    // Fixed field widths
    localparam int COORD_W  = 32;
    localparam int FREQ_W   = 32;
    localparam int AMP_W    = 17;   // Q1.16, 1.0 = 65536
    localparam int TOTAL_W  = 52;   // weighted noise sum, up to 16 octaves
    localparam int ASUM_W   = 21;   // amplitude sum, up to 16 octaves
    localparam int HEIGHT_W = 10;
    localparam int LIMIT_W  = 11;
    localparam int QUO_W    = 10;   // normalized offset magnitude, at most 1023
    localparam int DQ_W     = 31;   // dividend after the 2^30 scale is dropped

    localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;

    // Hash constants
    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_A = 32'd789221;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SEED           = 3'd0,
        REG_BASE_FREQUENCY = 3'd1,
        REG_PERSISTENCE    = 3'd2,
        REG_LACUNARITY     = 3'd3,
        REG_OCTAVE_COUNT   = 3'd4,
        REG_BASE_HEIGHT    = 3'd5,
        REG_HEIGHT_GAIN    = 3'd6,
        REG_COLUMN_HEIGHT  = 3'd7
    } cfg_index_t;

    // Per-request data that moves from octave to octave
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
        logic [FREQ_W-1:0]         freq;
        logic [AMP_W-1:0]          amp;
        logic signed [TOTAL_W-1:0] total;
        logic [ASUM_W-1:0]         asum;
    } oct_carry_t;

endpackage

// ----- hdl/fbm_octave.sv -----
// One noise octave: scale, hash, weight and accumulate, in eight stages.
// Depends on fbm_pkg.
module fbm_octave (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               active,
    input  logic signed [31:0] seed,
    input  logic [15:0]        persistence,
    input  logic [15:0]        lacunarity,
    input  logic               in_valid,
    input  fbm_pkg::oct_carry_t in_carry,
    output logic               out_valid,
    output fbm_pkg::oct_carry_t out_carry
);

    localparam int STAGES = 8;

    logic [STAGES-1:0]   v_reg;
    fbm_pkg::oct_carry_t c_reg [STAGES];

    // Saturate a product to the signed 48-bit range
    function automatic logic signed [47:0] sat48(input logic signed [63:0] p);
        logic signed [47:0] r;
        if (p > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (p < -64'sh0000_8000_0000_0000) begin
            r = -48'sh8000_0000_0000;
        end else begin
            r = p[47:0];
        end
        return r;
    endfunction

    // Valid bits advance with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    // Stage A: scale coordinates, step the frequency
    logic signed [63:0] px_next, pz_next;
    logic signed [63:0] px_reg, pz_reg;
    logic [47:0]        fprod;
    logic [39:0]        fshift;
    fbm_pkg::oct_carry_t ca_next;

    always_comb begin
        px_next = $signed(in_carry.x) * $signed({1'b0, in_carry.freq});
        pz_next = $signed(in_carry.z) * $signed({1'b0, in_carry.freq});
        fprod   = in_carry.freq * lacunarity;
        fshift  = fprod[47:8];
        ca_next = in_carry;
        ca_next.freq = (|fshift[39:32]) ? '1 : fshift[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= px_next;
            pz_reg   <= pz_next;
            c_reg[0] <= ca_next;
        end
    end

    // Stage B: saturate and form the hash input
    logic signed [47:0] sx, sz;
    logic signed [57:0] t_next, t_reg;

    always_comb begin
        sx = sat48(px_reg);
        sz = sat48(pz_reg);
        t_next = 58'(sx) * 58'sd57 + 58'(sz) * 58'sd131 + (58'(seed) <<< 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= t_next;
            c_reg[1] <= c_reg[0];
        end
    end

    // Stage C: truncate toward zero, saturate, pre-mix
    logic signed [57:0] tq;
    logic signed [31:0] n;
    logic [31:0]        m_next, m_c_reg;

    always_comb begin
        tq = t_reg[57] ? ((t_reg + 58'sd65535) >>> 16) : (t_reg >>> 16);
        if (tq > 58'sd2147483647) begin
            n = 32'sh7FFF_FFFF;
        end else if (tq < -58'sd2147483648) begin
            n = -32'sh8000_0000;
        end else begin
            n = tq[31:0];
        end
        m_next = {n[18:0], 13'b0} ^ n;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_c_reg  <= m_next;
            c_reg[2] <= c_reg[1];
        end
    end

    // Stage D: square
    logic [63:0] sq_full;
    logic [31:0] sq_reg, m_d_reg;

    assign sq_full = m_c_reg * m_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_full[31:0];
            m_d_reg  <= m_c_reg;
            c_reg[3] <= c_reg[2];
        end
    end

    // Stage E: first polynomial term
    logic [63:0] pa_full;
    logic [31:0] p2_next, p2_reg, m_e_reg;

    assign pa_full = sq_reg * fbm_pkg::HASH_MUL_A;
    assign p2_next = pa_full[31:0] + fbm_pkg::HASH_ADD_A;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg   <= p2_next;
            m_e_reg  <= m_d_reg;
            c_reg[4] <= c_reg[3];
        end
    end

    // Stage F: final product, fold into Q2.30 noise
    logic [63:0]        pb_full;
    logic [31:0]        hh;
    logic signed [31:0] noise_next, noise_reg;

    always_comb begin
        pb_full    = m_e_reg * p2_reg;
        hh         = pb_full[31:0] + fbm_pkg::HASH_ADD_B;
        noise_next = 32'sd1073741824 - $signed({1'b0, hh[30:0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            noise_reg <= noise_next;
            c_reg[5]  <= c_reg[4];
        end
    end

    // Stage G: weight by amplitude, decay the amplitude
    logic signed [49:0] prod_next, prod_reg;
    logic [32:0]        aprod;
    logic [16:0]        amp_n_reg;

    assign prod_next = noise_reg * $signed({1'b0, c_reg[5].amp});
    assign aprod     = c_reg[5].amp * persistence;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            amp_n_reg <= aprod[32:16];
            c_reg[6]  <= c_reg[5];
        end
    end

    // Stage H: accumulate when this octave is in use
    fbm_pkg::oct_carry_t ch_next;

    always_comb begin
        ch_next = c_reg[6];
        if (active) begin
            ch_next.total = c_reg[6].total + fbm_pkg::TOTAL_W'(prod_reg);
            ch_next.asum  = c_reg[6].asum + fbm_pkg::ASUM_W'(c_reg[6].amp);
        end
        ch_next.amp = amp_n_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[7] <= ch_next;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_carry = c_reg[7];

endmodule

// ----- hdl/fbm_norm.sv -----
// Normalizes the weighted sum, applies gain and base, clamps the height.
// Depends on fbm_pkg; bit-per-stage restoring divider.
module fbm_norm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [fbm_pkg::TOTAL_W-1:0]  total,
    input  logic [fbm_pkg::ASUM_W-1:0]          asum,
    input  logic [9:0]                          height_gain,
    input  logic [9:0]                          base_height,
    input  logic [fbm_pkg::LIMIT_W-1:0]         limit,
    output logic                                out_valid,
    output logic [fbm_pkg::HEIGHT_W-1:0]        height
);

    localparam int QW  = fbm_pkg::QUO_W;
    localparam int MW  = fbm_pkg::TOTAL_W - 1;

    // Stage 1: magnitude and sign
    logic          v1_reg;
    logic [MW-1:0] mag_reg;
    logic          neg1_reg;
    logic [fbm_pkg::ASUM_W-1:0] as1_reg;
    logic signed [fbm_pkg::TOTAL_W-1:0] abs_total;

    assign abs_total = total[fbm_pkg::TOTAL_W-1] ? -total : total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= abs_total[MW-1:0];
            neg1_reg <= total[fbm_pkg::TOTAL_W-1];
            as1_reg  <= asum;
        end
    end

    // Stage 2: apply gain, drop the 2^30 scale
    logic [MW+9:0] gprod;
    logic          v2_reg;
    logic [fbm_pkg::DQ_W-1:0] dq_reg;
    logic          neg2_reg;
    logic [fbm_pkg::ASUM_W-1:0] as2_reg;

    assign gprod = mag_reg * height_gain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg   <= gprod[30 +: fbm_pkg::DQ_W];
            neg2_reg <= neg1_reg;
            as2_reg  <= as1_reg;
        end
    end

    // Divider: one quotient bit per stage, most significant first
    logic [QW-1:0] dv_reg;
    logic [31:0]   rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [QW-1:0] neg_reg;
    logic [fbm_pkg::ASUM_W-1:0] as_reg [QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (en) begin
            dv_reg <= {dv_reg[QW-2:0], v2_reg};
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int BIT = QW - 1 - i;
        logic [31:0]   rem_in;
        logic [QW-1:0] q_in;
        logic          neg_in;
        logic [fbm_pkg::ASUM_W-1:0] as_in;
        logic [31:0]   dsh;

        if (i == 0) begin : g_first
            assign rem_in = 32'(dq_reg);
            assign q_in   = '0;
            assign neg_in = neg2_reg;
            assign as_in  = as2_reg;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign as_in  = as_reg[i-1];
        end

        assign dsh = 32'(as_in) << BIT;

        // Subtract the shifted divisor where it fits
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i] <= neg_in;
                as_reg[i]  <= as_in;
                if (rem_in >= dsh) begin
                    rem_reg[i] <= rem_in - dsh;
                    q_reg[i]   <= q_in | (QW'(1) << BIT);
                end else begin
                    rem_reg[i] <= rem_in;
                    q_reg[i]   <= q_in;
                end
            end
        end
    end

    // Output stage: sign, add base, clamp
    logic signed [11:0] off, hsum, hmax;
    logic [fbm_pkg::HEIGHT_W-1:0] h_next, h_reg;
    logic          vo_reg;

    always_comb begin
        off  = neg_reg[QW-1] ? -$signed({2'b0, q_reg[QW-1]}) : $signed({2'b0, q_reg[QW-1]});
        hsum = $signed({2'b0, base_height}) + off;
        hmax = $signed({1'b0, limit}) - 12'sd1;
        if (hsum < 12'sd1) begin
            h_next = fbm_pkg::HEIGHT_W'(1);
        end else if (hsum > hmax) begin
            h_next = hmax[fbm_pkg::HEIGHT_W-1:0];
        end else begin
            h_next = hsum[fbm_pkg::HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= dv_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg <= h_next;
        end
    end

    assign out_valid = vo_reg;
    assign height    = h_reg;

endmodule

// ----- hdl/fbm_value_noise_height.sv -----
// Top level of the fractal value-noise terrain height pipeline.
// Depends on fbm_pkg, fbm_octave and fbm_norm.
//
//  channel   direction  payload (lowest bit up)
//  s_axis    in         tdata[31:0] world_x, tdata[63:32] world_z
//  m_axis    out        tdata[9:0] height, tdata[15:10] zero
//  cfg       in         cfg_index selects the register, cfg_wdata its value
//
// One request enters per cycle unless the output stalls; the path runs through eight
// stages per octave, then magnitude, gain, the ten-stage quotient divider and the output stage.
// Reset (aresetn low, synchronous) clears all valid bits and loads config defaults.
// A stall on m_tready holds every stage; s_tready falls with it.
module fbm_value_noise_height #(
    parameter int MAX_OCTAVES       = fbm_pkg::DEF_MAX_OCTAVES,
    parameter int MAX_COLUMN_HEIGHT = fbm_pkg::DEF_MAX_COLUMN_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // world_x [31:0], world_z [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // height [9:0], zero fill [15:10]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int CAP = (MAX_COLUMN_HEIGHT < 1024) ? MAX_COLUMN_HEIGHT : 1024;

    // Configuration registers
    logic signed [31:0] seed_reg;
    logic [31:0] base_frequency_reg;
    logic [15:0] persistence_reg;
    logic [15:0] lacunarity_reg;
    logic [3:0]  octave_count_reg;
    logic [9:0]  base_height_reg;
    logic [9:0]  height_gain_reg;
    logic [10:0] column_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg           <= '0;
            base_frequency_reg <= 32'd655;
            persistence_reg    <= 16'd32768;
            lacunarity_reg     <= 16'd512;
            octave_count_reg   <= 4'd4;
            base_height_reg    <= 10'd64;
            height_gain_reg    <= 10'd32;
            column_height_reg  <= 11'd256;
        end else if (cfg_wr_en) begin
            case (fbm_pkg::cfg_index_t'(cfg_index))
                fbm_pkg::REG_SEED:           seed_reg           <= cfg_wdata;
                fbm_pkg::REG_BASE_FREQUENCY: base_frequency_reg <= cfg_wdata;
                fbm_pkg::REG_PERSISTENCE:    persistence_reg    <= cfg_wdata[15:0];
                fbm_pkg::REG_LACUNARITY:     lacunarity_reg     <= cfg_wdata[15:0];
                fbm_pkg::REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_wdata[3:0];
                fbm_pkg::REG_BASE_HEIGHT:    base_height_reg    <= cfg_wdata[9:0];
                fbm_pkg::REG_HEIGHT_GAIN:    height_gain_reg    <= cfg_wdata[9:0];
                fbm_pkg::REG_COLUMN_HEIGHT:  column_height_reg  <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Effective octave count and height limit
    logic [4:0]  octs;
    logic [10:0] limit;

    always_comb begin
        if (octave_count_reg == 4'd0) begin
            octs = 5'd1;
        end else if (32'(octave_count_reg) > MAX_OCTAVES) begin
            octs = 5'(MAX_OCTAVES);
        end else begin
            octs = {1'b0, octave_count_reg};
        end
        if (column_height_reg < 11'd2) begin
            limit = 11'd2;
        end else if (32'(column_height_reg) > CAP) begin
            limit = 11'(CAP);
        end else begin
            limit = column_height_reg;
        end
    end

    // Whole pipeline advances together unless the output is held
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Octave chain
    logic                v_chain [MAX_OCTAVES+1];
    fbm_pkg::oct_carry_t c_chain [MAX_OCTAVES+1];

    always_comb begin
        v_chain[0]       = s_tvalid;
        c_chain[0].x     = s_tdata[31:0];
        c_chain[0].z     = s_tdata[63:32];
        c_chain[0].freq  = base_frequency_reg;
        c_chain[0].amp   = fbm_pkg::AMP_ONE;
        c_chain[0].total = '0;
        c_chain[0].asum  = '0;
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        logic act;
        assign act = (5'(k) < octs);

        fbm_octave u_oct (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .active      (act),
            .seed        (seed_reg),
            .persistence (persistence_reg),
            .lacunarity  (lacunarity_reg),
            .in_valid    (v_chain[k]),
            .in_carry    (c_chain[k]),
            .out_valid   (v_chain[k+1]),
            .out_carry   (c_chain[k+1])
        );
    end

    // Normalize and clamp
    logic [9:0] height;

    fbm_norm u_norm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v_chain[MAX_OCTAVES]),
        .total       (c_chain[MAX_OCTAVES].total),
        .asum        (c_chain[MAX_OCTAVES].asum),
        .height_gain (height_gain_reg),
        .base_height (base_height_reg),
        .limit       (limit),
        .out_valid   (m_tvalid),
        .height      (height)
    );

    assign m_tdata = {6'b0, height};

endmodule

// ----- dv/tb_fbm_value_noise_height.sv -----
// Testbench for the fractal value-noise terrain height pipeline.
// Depends on fbm_pkg and fbm_value_noise_height; predicts heights in-line.
`timescale 1ns / 100ps

module tb_fbm_value_noise_height;

    localparam int LATENCY = 8 * fbm_pkg::DEF_MAX_OCTAVES + 13;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Shadow copy of the height settings
    logic signed [31:0] seed_q;
    logic [31:0]        freq_q;
    logic [15:0]        persist_q;
    logic [15:0]        lacun_q;
    logic [3:0]         octaves_q;
    logic [9:0]         base_q;
    logic [9:0]         gain_q;
    logic [10:0]        colh_q;

    logic [9:0] height_queue[$];
    int         errors = 0;
    int         send_idle = 0;
    int         recv_idle = 0;

    fbm_value_noise_height dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Value noise for one hash input, Q2.30
    function automatic longint lattice_noise(input logic [31:0] n);
        logic [31:0] m;
        logic [31:0] h;
        m = (n << 13) ^ n;
        h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
        return (64'sd1 <<< 30) - longint'(h);
    endfunction

    function automatic logic [9:0] predict_height(input logic signed [31:0] x,
                                                  input logic signed [31:0] z);
        longint unsigned f, a;
        longint total, asum, sx, sz, t, n, off, h, lim;
        int octs;
        f = freq_q; a = 65536; total = 0; asum = 0;
        octs = octaves_q == 0 ? 1 :
               (octaves_q > fbm_pkg::DEF_MAX_OCTAVES ? fbm_pkg::DEF_MAX_OCTAVES : octaves_q);
        for (int k = 0; k < octs; k++) begin
            sx = sat(longint'(x) * longint'(f), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
            sz = sat(longint'(z) * longint'(f), -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
            t = 57 * sx + 131 * sz + longint'(seed_q) * 65536;
            n = sat(t / 65536, -64'sd2147483648, 64'sd2147483647);
            total += lattice_noise(n[31:0]) * longint'(a);
            asum += longint'(a);
            a = (a * persist_q) >> 16;
            f = (f * lacun_q) >> 8;
            if (f > 64'hffffffff) f = 64'hffffffff;
        end
        off = (total * longint'(gain_q)) / (asum * (64'sd1 <<< 30));
        h = longint'(base_q) + off;
        lim = colh_q < 2 ? 2 : (colh_q > 1024 ? 1024 : colh_q);
        if (h < 1) h = 1;
        if (h > lim - 1) h = lim - 1;
        return h[9:0];
    endfunction

    // Write one register while the pipeline is empty
    task automatic write_reg(input fbm_pkg::cfg_index_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fbm_pkg::REG_SEED:           seed_q = val;
            fbm_pkg::REG_BASE_FREQUENCY: freq_q = val;
            fbm_pkg::REG_PERSISTENCE:    persist_q = val[15:0];
            fbm_pkg::REG_LACUNARITY:     lacun_q = val[15:0];
            fbm_pkg::REG_OCTAVE_COUNT:   octaves_q = val[3:0];
            fbm_pkg::REG_BASE_HEIGHT:    base_q = val[9:0];
            fbm_pkg::REG_HEIGHT_GAIN:    gain_q = val[9:0];
            default:                     colh_q = val[10:0];
        endcase
    endtask

    // Hold the request until accepted; drop valid only while idling
    task automatic send_column(input logic [31:0] x, input logic [31:0] z);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        height_queue.push_back(predict_height(x, z));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (height_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(0, 600) - 300;
            1: return $urandom_range(0, 200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // Check each returned height against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (height_queue.size() == 0) begin
                report_mismatch("height with no request pending");
            end else begin
                logic [9:0] want;
                want = height_queue.pop_front();
                if (m_tdata[9:0] !== want)
                    report_mismatch($sformatf("height %0d, want %0d", m_tdata[9:0], want));
                if (m_tdata[15:10] !== '0)
                    report_mismatch("nonzero fill in tdata");
            end
        end
    end

    // Receiver stall
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic test_edges;
        logic [31:0] ext[6] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h12345};
        foreach (ext[i]) send_column(ext[i], ext[5 - i]);
        send_column(32'h7fffffff, 32'h7fffffff);
        send_column(32'h80000000, 32'h80000000);
        drain();
    endtask

    task automatic test_settings_extremes;
        // zero octaves, max frequency, tiny column
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, 0);
        write_reg(fbm_pkg::REG_BASE_FREQUENCY, 32'hffffffff);
        write_reg(fbm_pkg::REG_COLUMN_HEIGHT, 0);
        write_reg(fbm_pkg::REG_SEED, 32'h80000000);
        send_column(32'h7fffffff, 32'h80000000);
        send_column(5, -7);
        drain();
        // octaves above the cap, full gain, zero persistence, column above the cap
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, 15);
        write_reg(fbm_pkg::REG_PERSISTENCE, 0);
        write_reg(fbm_pkg::REG_LACUNARITY, 16'hffff);
        write_reg(fbm_pkg::REG_HEIGHT_GAIN, 1023);
        write_reg(fbm_pkg::REG_BASE_HEIGHT, 0);
        write_reg(fbm_pkg::REG_COLUMN_HEIGHT, 11'h7ff);
        write_reg(fbm_pkg::REG_SEED, 32'h7fffffff);
        for (int i = 0; i < 6; i++) send_column($urandom, $urandom);
        drain();
        write_reg(fbm_pkg::REG_PERSISTENCE, 16'hffff);
        write_reg(fbm_pkg::REG_LACUNARITY, 0);
        write_reg(fbm_pkg::REG_BASE_HEIGHT, 1023);
        write_reg(fbm_pkg::REG_BASE_FREQUENCY, 0);
        for (int i = 0; i < 4; i++) send_column($urandom, $urandom);
        drain();
    endtask

    task automatic test_random_settings(input int items);
        write_reg(fbm_pkg::REG_SEED, $urandom);
        write_reg(fbm_pkg::REG_BASE_FREQUENCY,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(70000));
        write_reg(fbm_pkg::REG_PERSISTENCE, $urandom_range(65535));
        write_reg(fbm_pkg::REG_LACUNARITY, $urandom_range(65535));
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, $urandom_range(15));
        write_reg(fbm_pkg::REG_BASE_HEIGHT, $urandom_range(1023));
        write_reg(fbm_pkg::REG_HEIGHT_GAIN, $urandom_range(1023));
        write_reg(fbm_pkg::REG_COLUMN_HEIGHT, $urandom_range(2047));
        for (int i = 0; i < items; i++) send_column(rand_coord(), rand_coord());
        drain();
    endtask

    initial begin
        seed_q = 0; freq_q = 655; persist_q = 32768; lacun_q = 512;
        octaves_q = 4; base_q = 64; gain_q = 32; colh_q = 256;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 19; recv_idle = 84;
        test_edges();
        test_settings_extremes();
        for (int p = 0; p < 3; p++) test_random_settings(75);
        send_idle = 84; recv_idle = 19;
        for (int p = 0; p < 3; p++) test_random_settings(75);
        send_idle = 0; recv_idle = 0;
        for (int p = 0; p < 3; p++) test_random_settings(75);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/fbm_pkg.sv
hdl/fbm_octave.sv
hdl/fbm_norm.sv
hdl/fbm_value_noise_height.sv
dv/tb_fbm_value_noise_height.sv
